/* rtl/positional_list_table_macros.svh */
// Assertion macros shared by the positional list table RTL.
`ifndef POSITIONAL_LIST_TABLE_MACROS_SVH
`define POSITIONAL_LIST_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/plt_pkg.sv */
// Shared types and constants for the positional list table.
`default_nettype none

package plt_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int OP_W     = 3;
   localparam int POS_W    = 5;
   localparam int WORD_W   = 32;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH     = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT   = 3'd2;
   localparam logic [OP_W-1:0] OP_REM_LAST = 3'd3;
   localparam logic [OP_W-1:0] OP_REM_FRST = 3'd4;
   localparam logic [OP_W-1:0] OP_REM_AT   = 3'd5;
   localparam logic [OP_W-1:0] OP_DUMP     = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic dump_emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic op_dump;
      logic list_empty;
      logic dump_end;
   } stat_type;

endpackage

`default_nettype wire

/* rtl/positional_list_table.sv */
// Edits (append, push, insert, removes) run as capture, then one shift step across the
// cell row that also loads the result register, held until that register is free.
// A dump emits one result per stored entry, paced by rsp_ready, or one ST_EMPTY result.
// The next transaction is accepted while the previous result still waits in its register.
// Synchronous reset empties the list and clears handshake state; cell contents are not
// cleared and are never read before being written.
`default_nettype none

module positional_list_table #(
   parameter int CAPACITY = plt_pkg::CAPACITY_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire        [plt_pkg::OP_W-1:0]      req_op,
   input  wire        [plt_pkg::POS_W-1:0]     req_position,
   input  wire signed [plt_pkg::WORD_W-1:0]    req_value,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic signed [plt_pkg::WORD_W-1:0]   rsp_value_res,
   output logic       [plt_pkg::INDEX_W-1:0]   rsp_index,
   output logic       [plt_pkg::STATUS_W-1:0]  rsp_status,
   output logic                                rsp_last,
   output logic       [plt_pkg::COUNT_W-1:0]   rsp_count
);

   plt_pkg::cmd_type  cmd;
   plt_pkg::stat_type stat;

   plt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   plt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_op        (req_op),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_res (rsp_value_res),
      .rsp_index     (rsp_index),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last),
      .rsp_count     (rsp_count)
   );

endmodule

`default_nettype wire

/* rtl/plt_datapath.sv */
// Datapath: cell row, length, dump pointer and result register.
`default_nettype none
`include "positional_list_table_macros.svh"

module plt_datapath #(
   parameter int CAPACITY = plt_pkg::CAPACITY_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  plt_pkg::cmd_type                    cmd,
   output plt_pkg::stat_type                   stat,
   input  wire        [plt_pkg::OP_W-1:0]      req_op,
   input  wire        [plt_pkg::POS_W-1:0]     req_position,
   input  wire signed [plt_pkg::WORD_W-1:0]    req_value,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic signed [plt_pkg::WORD_W-1:0]   rsp_value_res,
   output logic       [plt_pkg::INDEX_W-1:0]   rsp_index,
   output logic       [plt_pkg::STATUS_W-1:0]  rsp_status,
   output logic                                rsp_last,
   output logic       [plt_pkg::COUNT_W-1:0]   rsp_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = (LW > plt_pkg::POS_W) ? LW : plt_pkg::POS_W;

   logic [plt_pkg::OP_W-1:0]   op_ff;
   logic [plt_pkg::POS_W-1:0]  pos_ff;
   logic [plt_pkg::WORD_W-1:0] value_ff;
   logic [LW-1:0]              len_ff;
   logic [LW-1:0]              len_in;
   logic [AW-1:0]              idx_ff;
   logic [AW-1:0]              idx_in;
   logic [plt_pkg::WORD_W-1:0] cells_ff [CAPACITY];
   logic [plt_pkg::WORD_W-1:0] cells_in [CAPACITY];

   logic                          rsp_valid_ff;
   logic [plt_pkg::WORD_W-1:0]    rsp_value_ff;
   logic [plt_pkg::INDEX_W-1:0]   rsp_index_ff;
   logic [plt_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic                          rsp_last_ff;
   logic [plt_pkg::COUNT_W-1:0]   rsp_count_ff;

   logic [CW-1:0]               pos_w;
   logic [CW-1:0]               len_w;
   logic [CW-1:0]               eff_w;
   logic [AW-1:0]               eff_addr;
   logic [AW-1:0]               rd_addr;
   logic [plt_pkg::WORD_W-1:0]  rd_word;
   logic [plt_pkg::STATUS_W-1:0] st;
   logic                        do_ins;
   logic                        do_rem;
   logic                        full;
   logic                        empty;
   logic                        out_free;
   logic                        dump_end;

   assign pos_w = CW'(pos_ff);
   assign len_w = CW'(len_ff);
   assign full  = (len_ff == LW'(CAPACITY));
   assign empty = (len_ff == '0);

   // Decode the held operation against the current length.
   always_comb begin
      do_ins = 1'b0;
      do_rem = 1'b0;
      st     = plt_pkg::ST_OK;
      eff_w  = pos_w;
      unique case (op_ff)
         plt_pkg::OP_APPEND, plt_pkg::OP_PUSH, plt_pkg::OP_INSERT: begin
            if (full) begin
               st = plt_pkg::ST_FULL;
            end else begin
               if (op_ff == plt_pkg::OP_APPEND) begin
                  eff_w = len_w;
               end else if (op_ff == plt_pkg::OP_PUSH) begin
                  eff_w = '0;
               end
               if (op_ff == plt_pkg::OP_INSERT && pos_w > len_w) begin
                  st = plt_pkg::ST_BADPOS;
               end else begin
                  do_ins = 1'b1;
               end
            end
         end
         plt_pkg::OP_REM_LAST, plt_pkg::OP_REM_FRST, plt_pkg::OP_REM_AT: begin
            if (empty) begin
               st = plt_pkg::ST_EMPTY;
            end else begin
               if (op_ff == plt_pkg::OP_REM_LAST) begin
                  eff_w = len_w - CW'(1);
               end else if (op_ff == plt_pkg::OP_REM_FRST) begin
                  eff_w = '0;
               end
               if (op_ff == plt_pkg::OP_REM_AT && pos_w >= len_w) begin
                  st = plt_pkg::ST_BADPOS;
               end else begin
                  do_rem = 1'b1;
               end
            end
         end
         plt_pkg::OP_DUMP: begin
            if (empty) begin
               st = plt_pkg::ST_EMPTY;
            end
         end
         default: begin
         end
      endcase
   end

   assign eff_addr = AW'(eff_w);
   assign rd_addr  = cmd.dump_emit ? idx_ff : eff_addr;
   assign rd_word  = cells_ff[rd_addr];

   always_comb begin
      if (do_ins) begin
         len_in = len_ff + LW'(1);
      end else if (do_rem) begin
         len_in = len_ff - LW'(1);
      end else begin
         len_in = len_ff;
      end
   end

   // Shift the cell row open at an insert, closed at a removal.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
      end
      if (do_ins) begin
         for (int i = 1; i < CAPACITY; i++) begin
            if (AW'(i) > eff_addr) begin
               cells_in[i] = cells_ff[i-1];
            end
         end
         for (int i = 0; i < CAPACITY; i++) begin
            if (AW'(i) == eff_addr) begin
               cells_in[i] = value_ff;
            end
         end
      end else if (do_rem) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if (AW'(i) >= eff_addr) begin
               cells_in[i] = cells_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         cells_ff <= cells_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
   end

   assign idx_in = cmd.capture ? '0 : AW'(idx_ff + AW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         idx_ff <= '0;
      end else begin
         if (cmd.exec) begin
            len_ff <= len_in;
         end
         if (cmd.capture || cmd.dump_emit) begin
            idx_ff <= idx_in;
         end
      end
   end

   assign dump_end = (LW'(idx_ff) == len_ff - LW'(1));
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec || cmd.dump_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_value_ff  <= do_rem ? rd_word : '0;
         rsp_index_ff  <= do_rem ? plt_pkg::INDEX_W'(eff_addr) : '0;
         rsp_status_ff <= st;
         rsp_last_ff   <= 1'b1;
         rsp_count_ff  <= plt_pkg::COUNT_W'(len_in);
      end else if (cmd.dump_emit) begin
         rsp_value_ff  <= rd_word;
         rsp_index_ff  <= plt_pkg::INDEX_W'(idx_ff);
         rsp_status_ff <= plt_pkg::ST_OK;
         rsp_last_ff   <= dump_end;
         rsp_count_ff  <= plt_pkg::COUNT_W'(len_ff);
      end
   end

   assign stat.out_free   = out_free;
   assign stat.op_dump    = (op_ff == plt_pkg::OP_DUMP);
   assign stat.list_empty = empty;
   assign stat.dump_end   = dump_end;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_index     = rsp_index_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_count     = rsp_count_ff;

   `PLT_ASSERT_NOW(a_load_into_free, clock, reset, cmd.exec || cmd.dump_emit, out_free, "result register overwritten")
   `PLT_ASSERT_NOW(a_len_bound, clock, reset, 1'b1, len_ff <= LW'(CAPACITY), "length above capacity")
   `PLT_ASSERT_NOW(a_dump_nonempty, clock, reset, cmd.dump_emit, !empty && stat.op_dump, "dump step on empty list")
   `PLT_ASSERT_NEXT(a_dump_last, clock, reset, cmd.dump_emit && dump_end, rsp_last_ff && rsp_valid_ff, "final dump entry not marked")

endmodule

`default_nettype wire

/* rtl/plt_ctrl.sv */
// Controller: sequences capture, edit and dump steps for one transaction.
`default_nettype none

module plt_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  plt_pkg::stat_type  stat,
   output plt_pkg::cmd_type   cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.op_dump && !stat.list_empty) begin
               state_in = S_DUMP;
            end else if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DUMP: begin
            // emit one entry each time the result register frees up
            if (stat.out_free) begin
               cmd.dump_emit = 1'b1;
               if (stat.dump_end) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire
